@@ sv/assert_macros.svh @@
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

@@ sv/dft_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dft_pkg;

  // Motor count and line view
  localparam int NUM_MOTORS  = 4;
  localparam int LINE_W      = 4;
  localparam int NUM_LINES   = (NUM_MOTORS < LINE_W) ? NUM_MOTORS : LINE_W;
  localparam int START_MOTOR = 3;

  // Field widths
  localparam int MOTOR_W   = 2;
  localparam int THR_W     = 16;
  localparam int CMD_W     = 6;
  localparam int IDLE_W    = 10;
  localparam int SPAN_W    = 11;
  localparam int VALUE_W   = 11;
  localparam int OFFSET_W  = 12;
  localparam int FRAME_W   = 16;
  localparam int TIME_W    = 16;
  localparam int BIT_CNT_W = $clog2(FRAME_W);
  localparam int PROD_W    = THR_W + SPAN_W;

  // Stream packing
  localparam int S_TDATA_W = 32;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 8;
  localparam int MOTOR_LSB = 0;
  localparam int THR_LSB   = MOTOR_LSB + MOTOR_W;
  localparam int CMD_LSB   = THR_LSB + THR_W;
  localparam int STOP_BIT  = CMD_LSB + CMD_W;
  localparam int BUSY_BIT  = LINE_W;

  // Register port
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Throttle mapping constants
  localparam logic [IDLE_W-1:0]   IDLE_MAX   = 10'd1000;
  localparam logic [SPAN_W-1:0]   SPAN_BIDIR = 11'd1000;
  localparam logic [SPAN_W-1:0]   SPAN_UNI   = 11'd2001;
  localparam logic [SPAN_W-1:0]   SPAN_ONE   = 11'd1000;
  localparam logic [SPAN_W-1:0]   SPAN_TWO   = 11'd2000;
  localparam logic [OFFSET_W-1:0] BASE_FWD   = 12'd48;
  localparam logic [OFFSET_W-1:0] BASE_REV   = 12'd1048;
  localparam logic [OFFSET_W-1:0] VALUE_MAX  = 12'd2047;
  localparam logic [THR_W-1:0]    CAP_FIRST  = 16'd65471;

  // Reset values of the registers
  localparam logic [IDLE_W-1:0] IDLE_RST     = 10'd30;
  localparam logic [TIME_W-1:0] PERIOD_RST   = 16'd559;
  localparam logic [TIME_W-1:0] ZERO_HI_RST  = 16'd167;
  localparam logic [TIME_W-1:0] ONE_HI_RST   = 16'd335;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_CMD  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_IDLE     = 3'd0,
    REG_BIDIR    = 3'd1,
    REG_REVERSE  = 3'd2,
    REG_PERIOD   = 3'd3,
    REG_ZERO_HI  = 3'd4,
    REG_ONE_HI   = 3'd5
  } reg_e;

  typedef struct packed {
    logic [IDLE_W-1:0] idle_lift;
    logic              bidirectional;
    logic              reverse_direction;
    logic [TIME_W-1:0] bit_period;
    logic [TIME_W-1:0] zero_high_time;
    logic [TIME_W-1:0] one_high_time;
  } cfg_t;

  typedef struct packed {
    op_e                 op;
    logic [MOTOR_W-1:0]  motor;
    logic [VALUE_W-1:0]  scaled;
    logic [OFFSET_W-1:0] offset;
    logic                stop;
    logic [CMD_W-1:0]    cmd;
  } entry_t;

  // Pack value and telemetry bit, append nibble-XOR checksum
  function automatic logic [FRAME_W-1:0] frame_of(input logic [VALUE_W-1:0] value,
                                                  input logic tel);
    logic [VALUE_W:0] p;
    logic [3:0]       cs;
    p  = {value, tel};
    cs = p[3:0] ^ p[7:4] ^ p[11:8];
    return {p, cs};
  endfunction

endpackage

`default_nettype wire

@@ sv/dft_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dft_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dft_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [dft_pkg::PDATA_W-1:0]   pwdata,
  output logic      [dft_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready,
  output dft_pkg::cfg_t                      cfg_o
);

  dft_pkg::cfg_t  cfg_q, cfg_d;
  dft_pkg::reg_e  idx;
  logic           wr_en;

  assign pready = 1'b1;
  assign idx    = dft_pkg::reg_e'(paddr[dft_pkg::PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // Decode a register write
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        dft_pkg::REG_IDLE:    cfg_d.idle_lift         = pwdata[dft_pkg::IDLE_W-1:0];
        dft_pkg::REG_BIDIR:   cfg_d.bidirectional     = pwdata[0];
        dft_pkg::REG_REVERSE: cfg_d.reverse_direction = pwdata[0];
        dft_pkg::REG_PERIOD:  cfg_d.bit_period        = pwdata[dft_pkg::TIME_W-1:0];
        dft_pkg::REG_ZERO_HI: cfg_d.zero_high_time    = pwdata[dft_pkg::TIME_W-1:0];
        dft_pkg::REG_ONE_HI:  cfg_d.one_high_time     = pwdata[dft_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    case (idx)
      dft_pkg::REG_IDLE:    prdata[dft_pkg::IDLE_W-1:0] = cfg_q.idle_lift;
      dft_pkg::REG_BIDIR:   prdata[0]                   = cfg_q.bidirectional;
      dft_pkg::REG_REVERSE: prdata[0]                   = cfg_q.reverse_direction;
      dft_pkg::REG_PERIOD:  prdata[dft_pkg::TIME_W-1:0] = cfg_q.bit_period;
      dft_pkg::REG_ZERO_HI: prdata[dft_pkg::TIME_W-1:0] = cfg_q.zero_high_time;
      dft_pkg::REG_ONE_HI:  prdata[dft_pkg::TIME_W-1:0] = cfg_q.one_high_time;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.idle_lift         <= dft_pkg::IDLE_RST;
      cfg_q.bidirectional     <= 1'b1;
      cfg_q.reverse_direction <= 1'b0;
      cfg_q.bit_period        <= dft_pkg::PERIOD_RST;
      cfg_q.zero_high_time    <= dft_pkg::ZERO_HI_RST;
      cfg_q.one_high_time     <= dft_pkg::ONE_HI_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/dft_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dft_front (
  input  wire logic [dft_pkg::S_TDATA_W-1:0] tdata_i,
  input  wire logic [dft_pkg::S_TUSER_W-1:0] tuser_i,
  input  wire dft_pkg::cfg_t                 cfg_i,
  output dft_pkg::entry_t                    entry_o
);

  logic [dft_pkg::IDLE_W-1:0]   idle;
  logic [dft_pkg::SPAN_W-1:0]   span;
  logic [dft_pkg::OFFSET_W-1:0] offset;
  logic [dft_pkg::THR_W-1:0]    thr;
  logic [dft_pkg::PROD_W-1:0]   prod;
  logic [dft_pkg::SPAN_W-1:0]   cap;
  logic [1:0]                   cap_dec;

  assign thr = tdata_i[dft_pkg::THR_LSB +: dft_pkg::THR_W];

  // Clamp the idle offset and pick span and base for the mapping mode
  always_comb begin
    idle = (cfg_i.idle_lift > dft_pkg::IDLE_MAX) ? dft_pkg::IDLE_MAX : cfg_i.idle_lift;
    if (cfg_i.bidirectional) begin
      span   = dft_pkg::SPAN_BIDIR - {1'b0, idle};
      offset = (cfg_i.reverse_direction ? dft_pkg::BASE_REV : dft_pkg::BASE_FWD)
               + {2'b00, idle};
    end else begin
      span   = dft_pkg::SPAN_UNI - {idle, 1'b0};
      offset = dft_pkg::BASE_FWD + {1'b0, idle, 1'b0};
    end
  end

  // Scale the fraction; from CAP_FIRST up use span - ceil(span/1000)
  assign prod = thr * span;

  always_comb begin
    if (span == '0)                   cap_dec = 2'd0;
    else if (span <= dft_pkg::SPAN_ONE) cap_dec = 2'd1;
    else if (span <= dft_pkg::SPAN_TWO) cap_dec = 2'd2;
    else                              cap_dec = 2'd3;
    cap = span - {{(dft_pkg::SPAN_W-2){1'b0}}, cap_dec};
  end

  // Classify the item into a queue entry
  always_comb begin
    entry_o.op     = dft_pkg::op_e'(tuser_i);
    entry_o.motor  = tdata_i[dft_pkg::MOTOR_LSB +: dft_pkg::MOTOR_W];
    entry_o.scaled = (thr >= dft_pkg::CAP_FIRST) ? cap
                     : prod[dft_pkg::PROD_W-1 -: dft_pkg::VALUE_W];
    entry_o.offset = offset;
    entry_o.stop   = tdata_i[dft_pkg::STOP_BIT];
    entry_o.cmd    = tdata_i[dft_pkg::CMD_LSB +: dft_pkg::CMD_W];
  end

endmodule

`default_nettype wire

@@ sv/dft_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dft_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire dft_pkg::entry_t  entry_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output dft_pkg::entry_t       head_o
);

  dft_pkg::entry_t                 slot_q [dft_pkg::QUEUE_DEPTH];
  logic [dft_pkg::QPTR_W-1:0]      wr_ptr_q, wr_ptr_d;
  logic [dft_pkg::QPTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [dft_pkg::QCNT_W-1:0]      count_q, count_d;

  assign full_o  = (count_q == dft_pkg::QCNT_W'(dft_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == dft_pkg::QPTR_W'(dft_pkg::QUEUE_DEPTH - 1)) ? '0
                 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == dft_pkg::QPTR_W'(dft_pkg::QUEUE_DEPTH - 1)) ? '0
                 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

@@ sv/dft_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dft_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dft_pkg::cfg_t               cfg_i,
  input  wire logic                        valid_i,
  input  wire dft_pkg::entry_t             entry_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [dft_pkg::LINE_W-1:0]       levels_o,
  output logic                             busy_o,
  output logic                             done_o
);

  logic [dft_pkg::FRAME_W-1:0]   staged_q [dft_pkg::NUM_MOTORS];
  logic [dft_pkg::FRAME_W-1:0]   staged_d [dft_pkg::NUM_MOTORS];
  logic [dft_pkg::FRAME_W-1:0]   shift_q  [dft_pkg::NUM_MOTORS];
  logic [dft_pkg::FRAME_W-1:0]   shift_d  [dft_pkg::NUM_MOTORS];
  logic [dft_pkg::BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [dft_pkg::TIME_W-1:0]    tick_cnt_q, tick_cnt_d;
  logic                          sending_q, sending_d;

  logic                          out_valid_q;
  logic [dft_pkg::LINE_W-1:0]    levels_q, levels_d;
  logic                          busy_q;
  logic                          done_q, done_d;

  logic [dft_pkg::OFFSET_W-1:0]  sum;
  logic [dft_pkg::VALUE_W-1:0]   value;
  logic [dft_pkg::FRAME_W-1:0]   load_frame;
  logic [dft_pkg::FRAME_W-1:0]   cmd_frame;
  logic [dft_pkg::TIME_W-1:0]    period;
  logic [dft_pkg::TIME_W-1:0]    tick_inc;
  logic                          start;
  logic                          view_now;
  logic [dft_pkg::TIME_W-1:0]    high;
  logic [dft_pkg::TIME_W-1:0]    view_tick;
  logic                          view_send;
  logic [dft_pkg::FRAME_W-1:0]   view_frame;

  assign pop_o       = valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign levels_o    = levels_q;
  assign busy_o      = busy_q;
  assign done_o      = done_q;

  // Finish the throttle value and build both frame kinds
  always_comb begin
    sum        = entry_i.offset + {1'b0, entry_i.scaled};
    value      = (sum > dft_pkg::VALUE_MAX) ? dft_pkg::VALUE_MAX[dft_pkg::VALUE_W-1:0]
                 : sum[dft_pkg::VALUE_W-1:0];
    if (entry_i.stop) value = '0;
    load_frame = dft_pkg::frame_of(value, 1'b0);
    cmd_frame  = dft_pkg::frame_of({{(dft_pkg::VALUE_W-dft_pkg::CMD_W){1'b0}}, entry_i.cmd},
                                   1'b1);
    period     = (cfg_i.bit_period == '0) ? dft_pkg::TIME_W'(1) : cfg_i.bit_period;
    tick_inc   = tick_cnt_q + 1'b1;
  end

  // Execute one entry on the frame state
  always_comb begin
    staged_d   = staged_q;
    shift_d    = shift_q;
    bit_cnt_d  = bit_cnt_q;
    tick_cnt_d = tick_cnt_q;
    sending_d  = sending_q;
    done_d     = 1'b0;
    start      = 1'b0;
    case (entry_i.op)
      dft_pkg::OP_LOAD: begin
        for (int m = 0; m < dft_pkg::NUM_MOTORS; m++) begin
          if (int'(entry_i.motor) == m) staged_d[m] = load_frame;
        end
        start = (int'(entry_i.motor) == dft_pkg::START_MOTOR);
      end
      dft_pkg::OP_CMD: begin
        for (int m = 0; m < dft_pkg::NUM_MOTORS; m++) begin
          staged_d[m] = cmd_frame;
        end
        start = 1'b1;
      end
      dft_pkg::OP_TICK: begin
        if (sending_q) begin
          if (tick_inc >= period) begin
            tick_cnt_d = '0;
            for (int m = 0; m < dft_pkg::NUM_MOTORS; m++) begin
              shift_d[m] = {shift_q[m][dft_pkg::FRAME_W-2:0], 1'b0};
            end
            if (bit_cnt_q == dft_pkg::BIT_CNT_W'(dft_pkg::FRAME_W - 1)) begin
              bit_cnt_d = '0;
              sending_d = 1'b0;
              done_d    = 1'b1;
            end else begin
              bit_cnt_d = bit_cnt_q + 1'b1;
            end
          end else begin
            tick_cnt_d = tick_inc;
          end
        end
      end
      default: ;
    endcase
    if (start) begin
      shift_d    = staged_d;
      bit_cnt_d  = '0;
      tick_cnt_d = '0;
      sending_d  = 1'b1;
    end
  end

  // Line levels: a tick shows the state before it, other items the state after
  always_comb begin
    view_now  = (entry_i.op == dft_pkg::OP_TICK);
    view_tick = view_now ? tick_cnt_q : tick_cnt_d;
    view_send = view_now ? sending_q : sending_d;
    levels_d  = '0;
    high      = '0;
    view_frame = '0;
    for (int m = 0; m < dft_pkg::NUM_LINES; m++) begin
      view_frame = view_now ? shift_q[m] : shift_d[m];
      high = view_frame[dft_pkg::FRAME_W-1] ? cfg_i.one_high_time : cfg_i.zero_high_time;
      levels_d[m] = view_send && (view_tick < high);
    end
  end

  // Frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < dft_pkg::NUM_MOTORS; m++) begin
        staged_q[m] <= '0;
        shift_q[m]  <= '0;
      end
      bit_cnt_q  <= '0;
      tick_cnt_q <= '0;
      sending_q  <= 1'b0;
    end else if (pop_o) begin
      staged_q   <= staged_d;
      shift_q    <= shift_d;
      bit_cnt_q  <= bit_cnt_d;
      tick_cnt_q <= tick_cnt_d;
      sending_q  <= sending_d;
    end
  end

  // Output register: hold while the result is stalled
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      levels_q <= levels_d;
      busy_q   <= sending_d;
      done_q   <= done_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/dshot_frame_transmitter_top.sv @@
// Two register stages, the queue and the output register; m_axis_tvalid is set when the
// item is popped from the queue, which waits while a stalled result is held. Throughput:
// one item per cycle while the output is not stalled; the two-entry queue and the output
// register let input and output stall independently, and the frame state updates once
// per item. Reset (rst_ni low, asynchronous): registers return to their defaults, staged
// and shifting frames and counters clear, m_axis_tvalid drops and the queue empties.
`timescale 1ns / 1ps
`default_nettype none

module dshot_frame_transmitter_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // motor[1:0], throttle[17:2], command[23:18], motors_stop[24], zero[31:25]
  input  wire logic [dft_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [dft_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // Output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // line_levels[3:0], busy_res[4], zero[7:5]
  output logic      [dft_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // frame_done
  output logic                                m_axis_tlast,
  // Register port
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [dft_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [dft_pkg::PDATA_W-1:0]    pwdata,
  output logic      [dft_pkg::PDATA_W-1:0]    prdata,
  output logic                                pready
);

  dft_pkg::cfg_t                 cfg;
  dft_pkg::entry_t               front_entry;
  dft_pkg::entry_t               head_entry;
  logic                          q_full;
  logic                          q_valid;
  logic                          q_pop;
  logic                          push;
  logic [dft_pkg::LINE_W-1:0]    levels;
  logic                          busy;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {{(dft_pkg::M_TDATA_W-dft_pkg::LINE_W-1){1'b0}}, busy, levels};

  dft_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dft_front u_front (
    .tdata_i (s_axis_tdata),
    .tuser_i (s_axis_tuser),
    .cfg_i   (cfg),
    .entry_o (front_entry)
  );

  dft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (front_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (head_entry)
  );

  dft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .valid_i     (q_valid),
    .entry_i     (head_entry),
    .pop_o       (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .levels_o    (levels),
    .busy_o      (busy),
    .done_o      (m_axis_tlast)
  );

endmodule

`default_nettype wire

@@ sv/dft_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dft_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [dft_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  // A finished frame leaves the transmitter idle
  `ASSERT_NEVER(a_done_idle, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast && m_axis_tdata[dft_pkg::BUSY_BIT], "frame done while still busy")

  // A driven line needs an active frame, or the tick that ended it
  `ASSERT_PROP(a_levels_busy, clk_i, rst_ni, (m_axis_tvalid && (m_axis_tdata[dft_pkg::LINE_W-1:0] != '0)) |-> (m_axis_tdata[dft_pkg::BUSY_BIT] || m_axis_tlast), "line high outside a frame")

  // A stalled result holds
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)), "stalled result changed")

endmodule

bind dshot_frame_transmitter_top dft_checker u_dft_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
